/* sv/ffpp_pkg.sv */
package ffpp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 64;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hC2;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h53;
    localparam logic [7:0] SUM_START       = 8'hFF;

    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [2:0] EV_CONSUMED = 3'd0;
    localparam logic [2:0] EV_OK       = 3'd1;
    localparam logic [2:0] EV_FAIL_A   = 3'd2;
    localparam logic [2:0] EV_FAIL_B   = 3'd3;
    localparam logic [2:0] EV_RESYNC   = 3'd4;
    localparam logic [2:0] EV_READ     = 3'd5;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [5:0] read_index;
    } in_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] frame_class;
        logic [7:0] frame_id;
        logic [7:0] frame_length;
        logic [7:0] read_data;
        logic       payload_truncated;
    } out_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] frame_class;
        logic [7:0] frame_id;
        logic [7:0] frame_length;
        logic       payload_truncated;
    } parse_res_t;

    typedef struct packed {
        logic       en;
        logic [7:0] index;
        logic [7:0] data;
    } store_wr_t;

endpackage

/* sv/ffpp_ram.sv */
module ffpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ffpp_parser.sv */
module ffpp_parser #(
    parameter int PAYLOAD_DEPTH = ffpp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  ffpp_pkg::in_t          item,
    input  logic                   cfg_write_en,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_data,
    output ffpp_pkg::parse_res_t   res,
    output ffpp_pkg::store_wr_t    store_wr
);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECKA,
        PH_CHECKB
    } phase_t;

    localparam logic [7:0] DEPTH_W = 8'(PAYLOAD_DEPTH);

    phase_t     phase_reg, phase_next;
    logic [7:0] sum_a_reg, sum_a_next;
    logic [7:0] sum_b_reg, sum_b_next;
    logic [7:0] class_reg, class_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic [2:0] event_next;
    logic [7:0] count_inc;
    logic [15:0] add_cur;
    logic [15:0] add_fresh;

    function automatic logic [15:0] sums_add(input logic [7:0] a_in, input logic [7:0] b_in,
                                             input logic [7:0] d);
        logic [8:0] a;
        logic [8:0] b;
        begin
            a = {1'b0, a_in} + {1'b0, d};
            if (a > 9'd255)
            begin
                a = a - 9'd255;
            end
            b = {1'b0, b_in} + a;
            if (b > 9'd255)
            begin
                b = b - 9'd255;
            end
            sums_add = {b[7:0], a[7:0]};
        end
    endfunction

    assign add_cur   = sums_add(sum_a_reg, sum_b_reg, item.rx_byte);
    assign add_fresh = sums_add(ffpp_pkg::SUM_START, ffpp_pkg::SUM_START, item.rx_byte);
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        length_next = length_reg;
        count_next  = count_reg;
        event_next  = ffpp_pkg::EV_CONSUMED;
        store_wr.en    = 1'b0;
        store_wr.index = count_reg;
        store_wr.data  = item.rx_byte;
        if (item.req_type == ffpp_pkg::REQ_READ)
        begin
            event_next = ffpp_pkg::EV_READ;
        end
        else
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    if (item.rx_byte == sync_first_reg)
                    begin
                        {sum_b_next, sum_a_next} = add_cur;
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (item.rx_byte == sync_second_reg)
                    begin
                        {sum_b_next, sum_a_next} = add_cur;
                        phase_next = PH_CLASS;
                    end
                    else if (item.rx_byte == sync_first_reg)
                    begin
                        {sum_b_next, sum_a_next} = add_fresh;
                        event_next = ffpp_pkg::EV_RESYNC;
                    end
                    else
                    begin
                        sum_a_next = ffpp_pkg::SUM_START;
                        sum_b_next = ffpp_pkg::SUM_START;
                        phase_next = PH_SYNC1;
                    end
                end
                PH_CLASS:
                begin
                    class_next = item.rx_byte;
                    {sum_b_next, sum_a_next} = add_cur;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    id_next = item.rx_byte;
                    {sum_b_next, sum_a_next} = add_cur;
                    phase_next = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    length_next = item.rx_byte;
                    {sum_b_next, sum_a_next} = add_cur;
                    count_next = 8'd0;
                    phase_next = (item.rx_byte == 8'd0) ? PH_CHECKA : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    store_wr.en = (count_reg < DEPTH_W);
                    {sum_b_next, sum_a_next} = add_cur;
                    if (count_inc >= length_reg)
                    begin
                        count_next = 8'd0;
                        phase_next = PH_CHECKA;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                PH_CHECKA:
                begin
                    if (item.rx_byte == sum_a_reg)
                    begin
                        phase_next = PH_CHECKB;
                    end
                    else
                    begin
                        sum_a_next = ffpp_pkg::SUM_START;
                        sum_b_next = ffpp_pkg::SUM_START;
                        phase_next = PH_SYNC1;
                        event_next = ffpp_pkg::EV_FAIL_A;
                    end
                end
                default:
                begin
                    event_next = (item.rx_byte == sum_b_reg) ? ffpp_pkg::EV_OK
                                                             : ffpp_pkg::EV_FAIL_B;
                    sum_a_next = ffpp_pkg::SUM_START;
                    sum_b_next = ffpp_pkg::SUM_START;
                    phase_next = PH_SYNC1;
                end
            endcase
        end
        store_wr.en = store_wr.en & step;
    end

    assign res.event_res         = event_next;
    assign res.frame_class       = class_next;
    assign res.frame_id          = id_next;
    assign res.frame_length      = length_next;
    assign res.payload_truncated = (length_next > DEPTH_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SYNC1;
            sum_a_reg       <= ffpp_pkg::SUM_START;
            sum_b_reg       <= ffpp_pkg::SUM_START;
            class_reg       <= 8'd0;
            id_reg          <= 8'd0;
            length_reg      <= 8'd0;
            count_reg       <= 8'd0;
            sync_first_reg  <= ffpp_pkg::SYNC_FIRST_RST;
            sync_second_reg <= ffpp_pkg::SYNC_SECOND_RST;
        end
        else
        begin
            if (step)
            begin
                phase_reg  <= phase_next;
                sum_a_reg  <= sum_a_next;
                sum_b_reg  <= sum_b_next;
                class_reg  <= class_next;
                id_reg     <= id_next;
                length_reg <= length_next;
                count_reg  <= count_next;
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    ffpp_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                    ffpp_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                    default:                   sync_first_reg  <= sync_first_reg;
                endcase
            end
        end
    end

endmodule

/* sv/fletcher_framed_packet_parser.sv */
// Framed packet parser with a Fletcher-style check over the byte stream.
// Input transactions on in_valid/in_ready carry either one received byte
// (req_type 0) or a read request for the payload store (req_type 1).
// Every input transaction produces exactly one output transaction on
// out_valid/out_ready in the cycle after it is accepted: the parse step and the
// payload store write or read all complete in the accepting cycle, and the
// store's registered read port supplies read_data with the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// in_ready is high whenever the output register is empty or is being emptied
// in the same cycle. When the receiver stalls, the result waits in the output
// register and one more input transaction is held off until it is taken.
// Reset puts the parser in the hunt for the first sync byte, loads both sums
// to 255, clears class, id and length, and restores the sync bytes to their
// defaults. Payload store contents are undefined until written by a frame.
// The user must write the sync bytes through cfg_write_en/cfg_index/cfg_data
// only while no transaction is in flight; the block does not enforce this.
module fletcher_framed_packet_parser #(
    parameter int PAYLOAD_DEPTH = ffpp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ffpp_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ffpp_pkg::out_t out_data,
    input  logic           cfg_write_en,
    input  logic           cfg_index,
    input  logic [7:0]     cfg_data
);

    localparam int         AW      = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [7:0] DEPTH_W = 8'(PAYLOAD_DEPTH);

    logic                 accept;
    logic                 step;
    logic                 rd_en;
    logic                 rd_in_range;
    ffpp_pkg::parse_res_t res;
    ffpp_pkg::store_wr_t  store_wr;
    logic [7:0]           ram_q;

    logic                 out_valid_reg;
    ffpp_pkg::parse_res_t res_reg;
    logic                 rd_hit_reg;

    assign in_ready    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign step        = accept && (in_data.req_type == ffpp_pkg::REQ_BYTE);
    assign rd_en       = accept && (in_data.req_type == ffpp_pkg::REQ_READ);
    assign rd_in_range = ({2'b00, in_data.read_index} < DEPTH_W);

    ffpp_parser #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_data),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .res         (res),
        .store_wr    (store_wr)
    );

    ffpp_ram #(
        .WIDTH(8),
        .DEPTH(PAYLOAD_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (store_wr.en),
        .waddr(AW'(store_wr.index)),
        .wdata(store_wr.data),
        .re   (rd_en),
        .raddr(AW'(in_data.read_index)),
        .rdata(ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg    <= res;
            rd_hit_reg <= rd_en && rd_in_range;
        end
    end

    assign out_valid                  = out_valid_reg;
    assign out_data.event_res         = res_reg.event_res;
    assign out_data.frame_class       = res_reg.frame_class;
    assign out_data.frame_id          = res_reg.frame_id;
    assign out_data.frame_length      = res_reg.frame_length;
    assign out_data.read_data         = rd_hit_reg ? ram_q : 8'd0;
    assign out_data.payload_truncated = res_reg.payload_truncated;

endmodule
